/* hdl/mcld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcld_pkg
// Shared types and constants of the motor current load detector.
// ----------------------------------------------------------------------------
package mcld_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int TRIG_W     = 8;
   localparam int TICK_W     = 16;
   localparam int SPEED_W    = 16;
   localparam int PHASE_W    = 3;
   localparam int RSP_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INRUSH_TRIGGER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_TRIGGER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RUNNING_FLOOR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOAD_TRIGGER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CONFIRM_TICKS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd6;

   // |speed| below 1.0 per second, speed in 1/256 units
   localparam logic [SPEED_W-1:0] STOP_POS_MAX = 16'h00FF;
   localparam logic [SPEED_W-1:0] STOP_NEG_MIN = 16'hFF01;

   localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_CODE_INRUSH  = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_CODE_RUN     = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_CODE_CONFIRM = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_CODE_HOLD    = 3'd4;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_INRUSH  = 5'b00010,
      PH_RUN     = 5'b00100,
      PH_CONFIRM = 5'b01000,
      PH_HOLD    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic              current_mode;
      logic [TRIG_W-1:0] inrush_trigger;
      logic [TRIG_W-1:0] settle_trigger;
      logic [TRIG_W-1:0] running_floor;
      logic [TRIG_W-1:0] load_trigger;
      logic [TICK_W-1:0] confirm_ticks;
      logic [TICK_W-1:0] debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               has_load;
   } result_type;

   function automatic logic [PHASE_W-1:0] phase_code(phase_type p);
      logic [PHASE_W-1:0] code;
      case (p)
         PH_INRUSH:  code = PHASE_CODE_INRUSH;
         PH_RUN:     code = PHASE_CODE_RUN;
         PH_CONFIRM: code = PHASE_CODE_CONFIRM;
         PH_HOLD:    code = PHASE_CODE_HOLD;
         default:    code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

/* hdl/mcld_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcld_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module mcld_csr
   import mcld_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CURRENT_MODE:   cfg_in.current_mode   = csr_wdata[0];
            REG_INRUSH_TRIGGER: cfg_in.inrush_trigger = csr_wdata[TRIG_W-1:0];
            REG_SETTLE_TRIGGER: cfg_in.settle_trigger = csr_wdata[TRIG_W-1:0];
            REG_RUNNING_FLOOR:  cfg_in.running_floor  = csr_wdata[TRIG_W-1:0];
            REG_LOAD_TRIGGER:   cfg_in.load_trigger   = csr_wdata[TRIG_W-1:0];
            REG_CONFIRM_TICKS:  cfg_in.confirm_ticks  = csr_wdata[TICK_W-1:0];
            REG_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/mcld_detect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcld_detect
// Phase machine, confirm counter and sensor debounce; one item per cycle while accept is high.
// ----------------------------------------------------------------------------
module mcld_detect
   import mcld_pkg::*;
#(
   parameter int CURRENT_BITS = 12,
   parameter int COUNT_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    accept,
   input  logic [CURRENT_BITS-1:0] current_a,
   input  logic [CURRENT_BITS-1:0] current_b,
   input  logic [SPEED_W-1:0]      drive_speed,
   input  logic                    sensor_low,
   output result_type              result
);

   localparam int SUM_W = CURRENT_BITS + 1;
   localparam int THR_W = TRIG_W + 4;
   localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;
   localparam int LIM_W = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

   phase_type             phase_ff, phase_in;
   logic                  flag_ff, flag_in;
   logic [COUNT_BITS-1:0] conf_cnt_ff, conf_cnt_in;
   logic [COUNT_BITS-1:0] db_cnt_ff, db_cnt_in;
   logic                  db_pend_ff, db_pend_in;

   logic [CMP_W-1:0]      sum, thr_inrush, thr_settle, thr_floor, thr_load;
   logic                  stopped, present;
   logic [COUNT_BITS-1:0] conf_up, db_next;
   logic                  conf_done, db_done;

   // average in amps == sum in 1/16 A, trigger scaled by 16
   assign sum        = CMP_W'(current_a) + CMP_W'(current_b);
   assign thr_inrush = CMP_W'({cfg.inrush_trigger, 4'b0000});
   assign thr_settle = CMP_W'({cfg.settle_trigger, 4'b0000});
   assign thr_floor  = CMP_W'({cfg.running_floor, 4'b0000});
   assign thr_load   = CMP_W'({cfg.load_trigger, 4'b0000});

   assign stopped = (drive_speed <= STOP_POS_MAX) || (drive_speed >= STOP_NEG_MIN);
   assign present = ~sensor_low;

   assign conf_up   = (conf_cnt_ff == CNT_MAX) ? CNT_MAX : conf_cnt_ff + CNT_ONE;
   assign conf_done = (conf_up == CNT_MAX) ||
                      (LIM_W'(conf_up) > LIM_W'(cfg.confirm_ticks));

   assign db_next = !db_pend_ff ? CNT_ONE :
                    (db_cnt_ff == CNT_MAX) ? CNT_MAX : db_cnt_ff + CNT_ONE;
   assign db_done = (db_next == CNT_MAX) ||
                    (LIM_W'(db_next) >= LIM_W'(cfg.debounce_ticks));

   always_comb begin
      phase_in    = phase_ff;
      flag_in     = flag_ff;
      conf_cnt_in = conf_cnt_ff;
      db_cnt_in   = db_cnt_ff;
      db_pend_in  = db_pend_ff;
      if (accept) begin
         if (cfg.current_mode) begin
            if (stopped && !flag_ff && present) begin
               flag_in = 1'b1;
            end else begin
               case (phase_ff)
                  PH_INRUSH: begin
                     flag_in = 1'b0;
                     if (sum < thr_settle) begin
                        phase_in = (sum < thr_floor) ? PH_IDLE : PH_RUN;
                     end
                  end
                  PH_RUN: begin
                     flag_in = 1'b0;
                     if (sum > thr_load) begin
                        phase_in    = PH_CONFIRM;
                        conf_cnt_in = '0;
                     end else if (sum < thr_floor) begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_CONFIRM: begin
                     conf_cnt_in = conf_up;
                     if (conf_done) begin
                        flag_in  = 1'b1;
                        phase_in = PH_HOLD;
                     end
                  end
                  PH_HOLD: begin
                     if (sum < thr_floor) begin
                        flag_in  = 1'b0;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     flag_in  = 1'b0;
                     phase_in = (sum > thr_inrush) ? PH_INRUSH : PH_IDLE;
                  end
               endcase
            end
         end else begin
            if (present == flag_ff) begin
               db_pend_in = 1'b0;
               db_cnt_in  = '0;
            end else if (db_done) begin
               flag_in    = present;
               db_pend_in = 1'b0;
               db_cnt_in  = '0;
            end else begin
               db_pend_in = 1'b1;
               db_cnt_in  = db_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         flag_ff     <= 1'b0;
         conf_cnt_ff <= '0;
         db_cnt_ff   <= '0;
         db_pend_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         flag_ff     <= flag_in;
         conf_cnt_ff <= conf_cnt_in;
         db_cnt_ff   <= db_cnt_in;
         db_pend_ff  <= db_pend_in;
      end
   end

   assign result.phase    = phase_code(phase_in);
   assign result.has_load = flag_in;

   a_db_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !db_pend_ff |-> (db_cnt_ff == '0))
      else $error("debounce count nonzero while not pending");

   a_confirm_entry_clears: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RUN && phase_in == PH_CONFIRM) |=> (conf_cnt_ff == '0))
      else $error("confirm count not cleared on entry");

endmodule

/* hdl/mcld_outbuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcld_outbuf
// Result register with one skid entry.
// ----------------------------------------------------------------------------
module mcld_outbuf
   import mcld_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_data,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop      = out_valid_ff && out_ready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty result register");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && out_valid_ff && !out_ready) |=> skid_valid_ff)
      else $error("item lost while result stalled");

   a_skid_keeps: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !pop) |=> (skid_valid_ff && $stable(skid_data_ff)))
      else $error("skid entry changed while stalled");

endmodule

/* hdl/motor_current_load_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_current_load_detector
// Load detection from averaged motor current or a debounced presence sensor.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | current_a, current_b, drive_speed, sensor_low
//  rsp     | out | rsp_tvalid/tready    | has_load, phase
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
//  One item per cycle while req_tready is high; its result is registered, in the result
//  register or, while that is stalled, the skid entry. The phase machine and debounce
//  update in the accept cycle; a result register plus one skid entry decouple the two sides.
//  req_tready drops only while the skid entry is occupied by a stalled result.
//  Reset is synchronous and clears all state and configuration except the result data registers.
// ----------------------------------------------------------------------------
module motor_current_load_detector
   import mcld_pkg::*;
#(
   parameter int CURRENT_BITS = 12,
   parameter int COUNT_BITS   = 16,
   localparam int REQ_DATA_W  = ((2 * CURRENT_BITS + SPEED_W + 1 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // current_a, current_b, drive_speed, sensor_low
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // has_load, phase
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int B_LSB  = CURRENT_BITS;
   localparam int S_LSB  = 2 * CURRENT_BITS;
   localparam int SL_BIT = 2 * CURRENT_BITS + SPEED_W;

   cfg_type    cfg;
   result_type step_result, rsp_result;
   logic       accept;

   assign accept = req_tvalid && req_tready;

   mcld_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mcld_detect #(
      .CURRENT_BITS (CURRENT_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_detect (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .accept      (accept),
      .current_a   (req_tdata[CURRENT_BITS-1:0]),
      .current_b   (req_tdata[B_LSB +: CURRENT_BITS]),
      .drive_speed (req_tdata[S_LSB +: SPEED_W]),
      .sensor_low  (req_tdata[SL_BIT]),
      .result      (step_result)
   );

   mcld_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (step_result),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_result.phase, rsp_result.has_load});

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for motor_current_load_detector. Ticks queued by the
// stimulus process are sent with random gaps; every accepted tick updates a
// local model of the phase machine and debounce, and each result item is
// compared with the oldest predicted verdict. Runs go through several
// register settings, sensor mode and current mode alike.
// ----------------------------------------------------------------------------
module testbench;
   import mcld_pkg::*;

   localparam int REQ_W = 48;

   typedef struct {
      logic               has_load;
      logic [PHASE_W-1:0] phase;
   } verdict_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // current_a, current_b, drive_speed, sensor_low
   logic [REQ_W-1:0]      req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // has_load, phase
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   motor_current_load_detector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // detector model state
   cfg_type            model_cfg     = '0;
   logic [PHASE_W-1:0] m_phase       = PHASE_CODE_IDLE;
   logic               m_flag        = 1'b0;
   logic [TICK_W-1:0]  m_confirm_cnt = '0;
   logic [TICK_W-1:0]  m_bounce_cnt  = '0;
   logic               m_bounce_pend = 1'b0;

   logic [REQ_W-1:0] tick_q[$];
   verdict_type      verdict_q[$];
   int               mismatches = 0;
   int               send_wait  = 0;
   int               recv_wait  = 0;
   bit               send_burst = 1'b0;
   bit               recv_burst = 1'b0;
   int               phase_ticks;

   function automatic logic [TICK_W-1:0] sat_inc(logic [TICK_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic bit reached(logic [TICK_W-1:0] c, logic [TICK_W-1:0] limit,
                                  bit strict);
      if (c == '1) return 1'b1;
      return strict ? (c > limit) : (c >= limit);
   endfunction

   function automatic verdict_type predict_tick(logic [REQ_W-1:0] d);
      logic [11:0]         a, b;
      logic [SPEED_W-1:0]  spd;
      logic                present, stopped;
      logic [12:0]         sum, th_inrush, th_settle, th_floor, th_load;
      verdict_type         v;
      a         = d[11:0];
      b         = d[23:12];
      spd       = d[39:24];
      present   = ~d[40];
      sum       = {1'b0, a} + {1'b0, b};
      stopped   = (spd <= STOP_POS_MAX) || (spd >= STOP_NEG_MIN);
      th_inrush = {1'b0, model_cfg.inrush_trigger, 4'h0};
      th_settle = {1'b0, model_cfg.settle_trigger, 4'h0};
      th_floor  = {1'b0, model_cfg.running_floor, 4'h0};
      th_load   = {1'b0, model_cfg.load_trigger, 4'h0};
      if (model_cfg.current_mode) begin
         if (stopped && !m_flag && present) begin
            m_flag = 1'b1;
         end else begin
            case (m_phase)
               PHASE_CODE_INRUSH: begin
                  m_flag = 1'b0;
                  if (sum < th_settle)
                     m_phase = (sum < th_floor) ? PHASE_CODE_IDLE : PHASE_CODE_RUN;
               end
               PHASE_CODE_RUN: begin
                  m_flag = 1'b0;
                  if (sum > th_load) begin
                     m_phase       = PHASE_CODE_CONFIRM;
                     m_confirm_cnt = '0;
                  end else if (sum < th_floor) begin
                     m_phase = PHASE_CODE_IDLE;
                  end
               end
               PHASE_CODE_CONFIRM: begin
                  m_confirm_cnt = sat_inc(m_confirm_cnt);
                  if (reached(m_confirm_cnt, model_cfg.confirm_ticks, 1'b1)) begin
                     m_flag  = 1'b1;
                     m_phase = PHASE_CODE_HOLD;
                  end
               end
               PHASE_CODE_HOLD: begin
                  if (sum < th_floor) begin
                     m_flag  = 1'b0;
                     m_phase = PHASE_CODE_IDLE;
                  end
               end
               default: begin
                  m_phase = PHASE_CODE_IDLE;
                  m_flag  = 1'b0;
                  if (sum > th_inrush) m_phase = PHASE_CODE_INRUSH;
               end
            endcase
         end
      end else if (present == m_flag) begin
         m_bounce_pend = 1'b0;
         m_bounce_cnt  = '0;
      end else begin
         m_bounce_cnt  = m_bounce_pend ? sat_inc(m_bounce_cnt) : TICK_W'(1);
         m_bounce_pend = 1'b1;
         if (reached(m_bounce_cnt, model_cfg.debounce_ticks, 1'b0)) begin
            m_flag        = present;
            m_bounce_pend = 1'b0;
            m_bounce_cnt  = '0;
         end
      end
      v.has_load = m_flag;
      v.phase    = m_phase;
      return v;
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait  = 0;
      end else begin
         if (req_tvalid && req_tready) verdict_q.push_back(predict_tick(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (tick_q.size() > 0) begin
               req_tdata  <= tick_q.pop_front();
               req_tvalid <= 1'b1;
               send_wait  = draw_wait(send_burst);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   verdict_type want_v;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("unexpected result item, tdata", rsp_tdata, 0);
            end else begin
               want_v = verdict_q.pop_front();
               if (rsp_tdata[0] !== want_v.has_load)
                  report_mismatch("has_load", rsp_tdata[0], want_v.has_load);
               if (rsp_tdata[3:1] !== want_v.phase)
                  report_mismatch("phase", rsp_tdata[3:1], want_v.phase);
            end
            recv_wait = draw_wait(recv_burst);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_tick(int a, int b, int spd, int sensor);
      tick_q.push_back({7'b0, 1'(sensor), 16'(spd), 12'(b), 12'(a)});
      phase_ticks++;
   endtask

   task automatic push_noise();
      push_tick($urandom_range(0, 4095), $urandom_range(0, 4095),
                $urandom_range(0, 65535), $urandom_range(0, 1));
   endtask

   // one tick whose current sum lies in [lo, hi] (1/16 A); mostly moving
   task automatic push_sum(int lo, int hi);
      int s, a_lo, a_hi, a, mag;
      if (lo < 0) lo = 0;
      if (hi > 8190) hi = 8190;
      if (lo > hi) return;
      s    = $urandom_range(hi, lo);
      a_lo = (s > 4095) ? s - 4095 : 0;
      a_hi = (s < 4095) ? s : 4095;
      a    = $urandom_range(a_hi, a_lo);
      mag  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(256, 32768);
      push_tick(a, s - a, $urandom_range(0, 1) ? -mag : mag, $urandom_range(0, 1));
   endtask

   // idle, inrush, settle, load spike, confirm, hold, drop
   task automatic push_signature();
      int f16, s16, l16, i16, band_hi, n;
      f16 = model_cfg.running_floor * 16;
      s16 = model_cfg.settle_trigger * 16;
      l16 = model_cfg.load_trigger * 16;
      i16 = model_cfg.inrush_trigger * 16;
      band_hi = (s16 - 1 < l16) ? s16 - 1 : l16;
      n = $urandom_range(0, 3);
      repeat (n) push_sum(0, f16 - 1);
      n = $urandom_range(1, 2);
      repeat (n) push_sum(i16 + 1, 8190);
      n = $urandom_range(1, 4);
      repeat (n) push_sum(f16, band_hi);
      push_sum(l16 + 1, 8190);
      n = (model_cfg.confirm_ticks < 8) ? model_cfg.confirm_ticks + $urandom_range(0, 2)
                                        : $urandom_range(0, 6);
      repeat (n) push_sum(0, 8190);
      n = $urandom_range(0, 4);
      repeat (n) push_sum(f16, 8190);
      push_sum(0, f16 - 1);
   endtask

   task automatic push_sensor_run();
      int len, sns;
      sns = $urandom_range(0, 1);
      len = (model_cfg.debounce_ticks < 8) ? $urandom_range(1, model_cfg.debounce_ticks + 3)
                                           : $urandom_range(1, 12);
      repeat (len)
         push_tick($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 65535), sns);
   endtask

   task automatic wait_drained();
      while (tick_q.size() > 0 || req_tvalid || verdict_q.size() > 0) @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_cfg(cfg_type c);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= REG_CURRENT_MODE;   csr_wdata <= 16'(c.current_mode);
      @(posedge clock);
      csr_index <= REG_INRUSH_TRIGGER; csr_wdata <= 16'(c.inrush_trigger);
      @(posedge clock);
      csr_index <= REG_SETTLE_TRIGGER; csr_wdata <= 16'(c.settle_trigger);
      @(posedge clock);
      csr_index <= REG_RUNNING_FLOOR;  csr_wdata <= 16'(c.running_floor);
      @(posedge clock);
      csr_index <= REG_LOAD_TRIGGER;   csr_wdata <= 16'(c.load_trigger);
      @(posedge clock);
      csr_index <= REG_CONFIRM_TICKS;  csr_wdata <= c.confirm_ticks;
      @(posedge clock);
      csr_index <= REG_DEBOUNCE_TICKS; csr_wdata <= c.debounce_ticks;
      @(posedge clock);
      csr_we <= 1'b0;
      model_cfg = c;
   endtask

   function automatic cfg_type random_current_cfg();
      cfg_type c;
      int f, s, l, i;
      f = $urandom_range(1, 60);
      s = f + $urandom_range(1, 50);
      l = ($urandom_range(0, 3) == 0) ? $urandom_range(s, f) : s + $urandom_range(0, 40);
      i = l + $urandom_range(0, 60);
      if (i > 255) i = 255;
      c.current_mode   = 1'b1;
      c.inrush_trigger = 8'(i);
      c.settle_trigger = 8'(s);
      c.running_floor  = 8'(f);
      c.load_trigger   = 8'(l);
      c.confirm_ticks  = 16'($urandom_range(0, 6));
      c.debounce_ticks = 16'($urandom_range(0, 65535));
      return c;
   endfunction

   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      cfg_type c;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: current signature with thresholds 60/30/10/40 A, confirm 2
      c = '{current_mode: 1'b1, inrush_trigger: 8'd60, settle_trigger: 8'd30,
            running_floor: 8'd10, load_trigger: 8'd40, confirm_ticks: 16'd2,
            debounce_ticks: 16'd3};
      apply_cfg(c);
      send_burst = 1'b1;
      push_tick(0, 0, 16'h8000, 1);
      push_tick(4095, 4095, 16'h7FFF, 0);     // inrush, sensor ignored while moving
      push_tick(160, 160, 16'h0100, 1);       // settle into the band
      push_tick(400, 400, 16'hFF00, 1);       // load spike
      push_tick(0, 0, 16'h1000, 1);
      push_tick(0, 0, 16'h1000, 1);
      push_tick(0, 0, 16'h1000, 1);           // confirm delay done
      push_tick(300, 300, 16'h0000, 0);       // stopped while holding
      push_tick(0, 0, 16'h0100, 1);           // below floor
      push_tick(0, 0, 16'h00FF, 0);           // forced detect
      push_tick(0, 0, 16'h00FF, 0);
      push_tick(0, 0, 16'hFF01, 0);           // forced detect, negative edge of stop
      push_tick(5, 5, 16'hFF00, 0);
      push_tick(4095, 0, 16'h0000, 1);        // stopped without sensor runs phases
      push_tick(0, 4095, 16'h7FFF, 1);
      push_tick(10, 10, 16'h8000, 1);         // inrush straight back to idle
      wait_drained();

      // directed: debounce of three ticks
      c.current_mode = 1'b0;
      apply_cfg(c);
      push_tick(4095, 4095, 0, 0);
      push_tick(0, 0, 16'h8000, 0);
      push_tick(1, 2, 16'h7FFF, 0);
      push_tick(3, 4, 0, 1);
      push_tick(3, 4, 0, 0);
      push_tick(5, 6, 0, 1);
      push_tick(5, 6, 0, 1);
      push_tick(5, 6, 0, 1);
      push_tick(5, 6, 0, 0);
      send_burst = 1'b0;
      wait_drained();

      for (int p = 0; p < 13; p++) begin
         case (p)
            0: c = '{current_mode: 1'b1, default: '0};
            1: c = '{current_mode: 1'b1, inrush_trigger: 8'hFF, settle_trigger: 8'hFF,
                     running_floor: 8'hFF, load_trigger: 8'hFF,
                     confirm_ticks: 16'hFFFF, debounce_ticks: 16'hFFFF};
            2: c = '{current_mode: 1'b0, debounce_ticks: 16'd0, default: '0};
            3: c = '{current_mode: 1'b0, debounce_ticks: 16'd1, default: '0};
            4: c = '{current_mode: 1'b0, debounce_ticks: 16'hFFFF, default: '0};
            default: begin
               c = random_current_cfg();
               if (p % 3 == 0) begin
                  c.current_mode   = 1'b0;
                  c.debounce_ticks = 16'($urandom_range(2, 6));
               end
            end
         endcase
         apply_cfg(c);
         send_burst  = ($urandom_range(0, 3) == 0);
         recv_burst  = ($urandom_range(0, 3) == 0);
         phase_ticks = 0;
         while (phase_ticks < 48) begin
            if ($urandom_range(0, 4) == 0) push_noise();
            else if (model_cfg.current_mode) push_signature();
            else push_sensor_run();
         end
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
